// ===== hdl/mme_pkg.sv =====
// Shared types and constants for the 4x4 fixed-point matrix multiply engine.
// No dependencies; used by mme_cell, mme_scale and the top level.
package mme_pkg;

  // Matrix geometry
  localparam int unsigned DIM      = 4;
  localparam int unsigned SLOT_W   = 2;   // index of a row or column
  localparam int unsigned IDX_W    = 4;   // column-major element position
  localparam int unsigned VALUE_W  = 32;  // width of the element fields on the ports
  localparam logic [IDX_W-1:0] LAST_POS = 4'd15;

  // Store selects carried in a request
  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  // One request: an element write, optionally followed by a product run
  typedef struct packed {
    logic                       matrix_select;
    logic [IDX_W-1:0]           element_index;
    logic signed [VALUE_W-1:0]  element_value;
    logic                       go;
    logic                       write_back;
  } mme_req_t;

  // One product element
  typedef struct packed {
    logic [IDX_W-1:0]           product_index;
    logic signed [VALUE_W-1:0]  product_value;
    logic                       saturated;
    logic                       last;
  } mme_rsp_t;

  // Token travelling down the chain of cells
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  pos;   // {column j, row i}
  } mme_tag_t;

  // Write strobe into one slot of a cell store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } mme_wr_t;

endpackage

// ===== hdl/mme_cell.sv =====
// One multiply-accumulate cell of the chain: holds column k of the first matrix
// and row k of the second, adds its term to the partial sum passing through.
// Depends on mme_pkg.
module mme_cell #(
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned SUM_WIDTH     = 66
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // element loads
  input  mme_pkg::mme_wr_t                wr_a_i,
  input  mme_pkg::mme_wr_t                wr_b_i,
  input  logic signed [ELEMENT_WIDTH-1:0] wr_data_i,
  // write-back capture and commit
  input  mme_pkg::mme_wr_t                wb_i,
  input  logic signed [ELEMENT_WIDTH-1:0] wb_data_i,
  input  logic                            commit_i,
  // chain
  input  mme_pkg::mme_tag_t               tag_i,
  input  logic signed [SUM_WIDTH-1:0]     sum_i,
  output mme_pkg::mme_tag_t               tag_o,
  output logic signed [SUM_WIDTH-1:0]     sum_o
);

  localparam int unsigned PROD_W = 2 * ELEMENT_WIDTH;

  logic signed [ELEMENT_WIDTH-1:0] a_q  [mme_pkg::DIM];  // first(col k, row i)
  logic signed [ELEMENT_WIDTH-1:0] b_q  [mme_pkg::DIM];  // second(col j, row k)
  logic signed [ELEMENT_WIDTH-1:0] wb_q [mme_pkg::DIM];  // pending write-back column

  mme_pkg::mme_tag_t           tag1_q, tag2_q;
  logic signed [SUM_WIDTH-1:0] psum1_q, sum2_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [PROD_W-1:0]    prod_d;
  logic signed [SUM_WIDTH-1:0] sum2_d;

  // Element stores; write-back commit replaces the whole first-matrix column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < mme_pkg::DIM; s++) begin
        a_q[s] <= '0;
        b_q[s] <= '0;
      end
    end else begin
      if (commit_i) begin
        a_q <= wb_q;
      end else if (wr_a_i.en) begin
        a_q[wr_a_i.slot] <= wr_data_i;
      end
      if (wr_b_i.en) begin
        b_q[wr_b_i.slot] <= wr_data_i;
      end
    end
  end

  // Write-back staging
  always_ff @(posedge clk_i) begin
    if (wb_i.en) begin
      wb_q[wb_i.slot] <= wb_data_i;
    end
  end

  // Stage 1 multiplies, stage 2 accumulates
  assign prod_d = a_q[tag_i.pos[mme_pkg::SLOT_W-1:0]]
                * b_q[tag_i.pos[mme_pkg::IDX_W-1:mme_pkg::SLOT_W]];
  assign sum2_d = psum1_q + SUM_WIDTH'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    psum1_q <= sum_i;
    sum2_q  <= sum2_d;
  end

  assign tag_o = tag2_q;
  assign sum_o = sum2_q;

endmodule

// ===== hdl/mme_scale.sv =====
// Output stage: drops the fraction bits of the exact dot product, saturates
// to the element range and registers the result. Depends on mme_pkg.
module mme_scale #(
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned SUM_WIDTH     = 66
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mme_pkg::mme_tag_t           tag_i,
  input  logic signed [SUM_WIDTH-1:0] sum_i,
  output logic                        valid_o,
  output mme_pkg::mme_rsp_t           rsp_o
);

  localparam logic signed [ELEMENT_WIDTH-1:0] MAX_VAL = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
  localparam logic signed [ELEMENT_WIDTH-1:0] MIN_VAL = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

  logic signed [SUM_WIDTH-1:0]       shifted;
  logic [SUM_WIDTH-ELEMENT_WIDTH:0]  upper;
  logic                              fits;
  logic signed [ELEMENT_WIDTH-1:0]   value;
  logic                              valid_q;
  mme_pkg::mme_rsp_t                 rsp_d, rsp_q;

  // Arithmetic shift rounds toward minus infinity; fits when the bits above
  // the element sign are all copies of it
  assign shifted = sum_i >>> FRAC_BITS;
  assign upper   = shifted[SUM_WIDTH-1:ELEMENT_WIDTH-1];
  assign fits    = (&upper) | ~(|upper);
  assign value   = fits ? shifted[ELEMENT_WIDTH-1:0] : (sum_i[SUM_WIDTH-1] ? MIN_VAL : MAX_VAL);

  always_comb begin
    rsp_d.product_index = tag_i.pos;
    rsp_d.product_value = mme_pkg::VALUE_W'(value);
    rsp_d.saturated     = ~fits;
    rsp_d.last          = (tag_i.pos == mme_pkg::LAST_POS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== hdl/matrix4x4_multiply_engine_core.sv =====
// Top level of the 4x4 fixed-point matrix multiply engine: sequencer, element
// load decode and a chain of four mme_cell instances feeding mme_scale. Depends on mme_pkg.
//
// Each request writes one element into the first or second matrix; requests
// without go never raise busy, so loads stream at one per cycle while no run
// is in progress. A request with go starts a run that issues the sixteen result
// positions in order, one per cycle, into a chain of four multiply-add cells
// (two register stages each) followed by a registered saturation stage. Results
// appear on valid_o/rsp_o one per cycle, positions 0 to 15, and cannot be held
// off. busy rises after the go request and stays high until the last result is
// out, and with write-back through a final commit state that copies the product
// into the first matrix. Both stores are cleared by reset; no clearing pass is needed.
module matrix4x4_multiply_engine_core #(
  parameter int unsigned FRAC_BITS     = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mme_pkg::mme_req_t  req_i,
  output logic               valid_o,
  output mme_pkg::mme_rsp_t  rsp_o
);

  localparam int unsigned SUM_WIDTH = 2 * ELEMENT_WIDTH + 2;
  localparam int unsigned DIM       = mme_pkg::DIM;
  localparam int unsigned SLOT_W    = mme_pkg::SLOT_W;
  localparam int unsigned IDX_W     = mme_pkg::IDX_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             wbmode_q, wbmode_d;
  logic             accept;
  logic             commit;

  mme_pkg::mme_tag_t           tag_c [DIM+1];
  logic signed [SUM_WIDTH-1:0] sum_c [DIM+1];
  logic signed [ELEMENT_WIDTH-1:0] wr_data;
  logic signed [ELEMENT_WIDTH-1:0] wb_data;

  assign accept  = start & ~busy;
  assign busy    = (state_q != ST_IDLE);
  assign commit  = (state_q == ST_COMMIT);
  assign wr_data = req_i.element_value[ELEMENT_WIDTH-1:0];
  assign wb_data = rsp_o.product_value[ELEMENT_WIDTH-1:0];

  // Run sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    wbmode_d = wbmode_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.go) begin
          state_d  = ST_ISSUE;
          cnt_d    = '0;
          wbmode_d = req_i.write_back;
        end
      end
      ST_ISSUE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == mme_pkg::LAST_POS) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (valid_o && rsp_o.last) begin
          state_d = wbmode_q ? ST_COMMIT : ST_IDLE;
        end
      end
      ST_COMMIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      wbmode_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      wbmode_q <= wbmode_d;
    end
  end

  // Head of the chain: one position per cycle during issue, zero partial sum
  assign tag_c[0].valid = (state_q == ST_ISSUE);
  assign tag_c[0].pos   = cnt_q;
  assign sum_c[0]       = '0;

  // Chain of cells; cell k holds first column k and second row k
  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mme_pkg::mme_wr_t wr_a, wr_b, wb;

    assign wr_a.en   = accept && (req_i.matrix_select == mme_pkg::SEL_FIRST)
                       && (req_i.element_index[IDX_W-1:SLOT_W] == SLOT_W'(k));
    assign wr_a.slot = req_i.element_index[SLOT_W-1:0];
    assign wr_b.en   = accept && (req_i.matrix_select == mme_pkg::SEL_SECOND)
                       && (req_i.element_index[SLOT_W-1:0] == SLOT_W'(k));
    assign wr_b.slot = req_i.element_index[IDX_W-1:SLOT_W];
    // product (col j, row i) becomes first(col j, row i)
    assign wb.en     = valid_o && wbmode_q
                       && (rsp_o.product_index[IDX_W-1:SLOT_W] == SLOT_W'(k));
    assign wb.slot   = rsp_o.product_index[SLOT_W-1:0];

    mme_cell #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .SUM_WIDTH     (SUM_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_a_i    (wr_a),
      .wr_b_i    (wr_b),
      .wr_data_i (wr_data),
      .wb_i      (wb),
      .wb_data_i (wb_data),
      .commit_i  (commit),
      .tag_i     (tag_c[k]),
      .sum_i     (sum_c[k]),
      .tag_o     (tag_c[k+1]),
      .sum_o     (sum_c[k+1])
    );
  end

  // Scale, saturate and register the result
  mme_scale #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_c[DIM]),
    .sum_i   (sum_c[DIM]),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  // Results only come out during a run
  a_valid_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobe outside a run");

  // Results of a run are contiguous and in position order
  a_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !rsp_o.last) |=> (valid_o &&
      rsp_o.product_index == IDX_W'($past(rsp_o.product_index) + 1'b1)))
    else $error("result positions not consecutive");

  // A go request starts a run
  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.go) |=> (busy && tag_c[0].valid && cnt_q == '0))
    else $error("go request did not start issuing");

  // Without write-back the run ends right after the last result
  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.last && !wbmode_q) |=> !busy)
    else $error("run did not end after last result");

endmodule
